/* design/iaf_pkg.sv */
// Package: payload types, format codes and character constants for the ASCII formatter.
package iaf_pkg;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  opcode;
  } in_t;

  typedef struct packed {
    logic [6:0] ascii_char;
    logic       last_char;
    logic [5:0] char_count;
  } out_t;

  localparam logic [3:0] OP_HEX8   = 4'd0;
  localparam logic [3:0] OP_HEX16  = 4'd1;
  localparam logic [3:0] OP_HEX32  = 4'd2;
  localparam logic [3:0] OP_UDEC16 = 4'd3;
  localparam logic [3:0] OP_SDEC16 = 4'd4;
  localparam logic [3:0] OP_UDEC32 = 4'd5;
  localparam logic [3:0] OP_SDEC32 = 4'd6;
  localparam logic [3:0] OP_BIN16  = 4'd7;
  localparam logic [3:0] OP_BIN32  = 4'd8;

  localparam int unsigned DEC_DIGITS = 10;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_ALPHA = 7'h37;

  function automatic logic [6:0] digit_char(input logic [3:0] nibble);
    logic [6:0] base;
    base = (nibble < 4'd10) ? CHAR_ZERO : CHAR_ALPHA;
    return base + {3'b000, nibble};
  endfunction

endpackage

/* design/iaf_stream_if.sv */
// Interface: valid/ready stream channel with a typed payload.
interface iaf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/integer_to_ascii_formatter.sv */
// Top level: serial integer to ASCII formatter (hex, binary, decimal).
//
// Usage:
//   item_in  carries value and opcode; a transfer starts one run of characters.
//   item_out carries one character per transfer, most significant first, with
//   last_char and char_count set on the final character of the run.
//   item_in.ready is high only while no run is in progress; an unused opcode
//   is taken and dropped without output.
// Sequence:
//   hex and binary: a load, then the characters shifted out of the source register.
//   decimal: a load, shift-and-add-3 conversion of 16 or 32 input bits (one input
//   bit per cycle), stripping of leading zero digits (at least one digit is kept),
//   then the sign if the value is negative, then the remaining digits.
//   The output register frees the last character, so the next load follows
//   right after the final character is registered.
// Reset: rst clears the state machine and the output valid.
// Stall: while item_out.valid is high and item_out.ready is low the output register
//   holds its character and sign and digit output pauses; no character is lost or repeated.
module integer_to_ascii_formatter (
  input  logic                clk,
  input  logic                rst,
  iaf_stream_if.sink          item_in,
  iaf_stream_if.source        item_out
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    MODE_HEX = 2'd0,
    MODE_BIN = 2'd1,
    MODE_DEC = 2'd2
  } mode_t;

  state_t            state;
  mode_t             mode;
  logic              neg;
  logic [31:0]       src;
  logic [39:0]       bcd;
  logic [5:0]        bitcnt;
  logic [5:0]        rem;
  logic [5:0]        cnt;
  logic              o_valid;
  iaf_pkg::out_t     o_data;

  logic              ld_ok;
  mode_t             ld_mode;
  logic              ld_neg;
  logic [31:0]       ld_src;
  logic [5:0]        ld_rem;
  logic [5:0]        ld_bits;
  logic [15:0]       v16;
  logic [15:0]       mag16;
  logic [31:0]       mag32;
  logic [39:0]       bcd_adj;
  logic [3:0]        emit_nib;
  logic              emit_last;
  logic              out_free;
  logic              char_load;

  assign item_in.ready  = (state == ST_IDLE);
  assign item_out.valid = o_valid;
  assign item_out.data  = o_data;
  assign out_free       = !o_valid || item_out.ready;
  assign char_load      = ((state == ST_SIGN) || (state == ST_EMIT)) && out_free;

  assign v16   = item_in.data.value[15:0];
  assign mag16 = v16[15] ? (~v16 + 16'd1) : v16;
  assign mag32 = item_in.data.value[31] ? (~item_in.data.value + 32'd1) : item_in.data.value;

  always_comb begin
    ld_ok   = 1'b1;
    ld_mode = MODE_HEX;
    ld_neg  = 1'b0;
    ld_src  = item_in.data.value;
    ld_rem  = 6'(iaf_pkg::DEC_DIGITS);
    ld_bits = 6'd32;
    case (item_in.data.opcode)
      iaf_pkg::OP_HEX8: begin
        ld_src = {item_in.data.value[7:0], 24'd0};
        ld_rem = 6'd2;
      end
      iaf_pkg::OP_HEX16: begin
        ld_src = {v16, 16'd0};
        ld_rem = 6'd4;
      end
      iaf_pkg::OP_HEX32: begin
        ld_rem = 6'd8;
      end
      iaf_pkg::OP_UDEC16: begin
        ld_mode = MODE_DEC;
        ld_src  = {v16, 16'd0};
        ld_bits = 6'd16;
      end
      iaf_pkg::OP_SDEC16: begin
        ld_mode = MODE_DEC;
        ld_neg  = v16[15];
        ld_src  = {mag16, 16'd0};
        ld_bits = 6'd16;
      end
      iaf_pkg::OP_UDEC32: begin
        ld_mode = MODE_DEC;
      end
      iaf_pkg::OP_SDEC32: begin
        ld_mode = MODE_DEC;
        ld_neg  = item_in.data.value[31];
        ld_src  = mag32;
      end
      iaf_pkg::OP_BIN16: begin
        ld_mode = MODE_BIN;
        ld_src  = {v16, 16'd0};
        ld_rem  = 6'd16;
      end
      iaf_pkg::OP_BIN32: begin
        ld_mode = MODE_BIN;
        ld_rem  = 6'd32;
      end
      default: begin
        ld_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < iaf_pkg::DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? (bcd[4*i +: 4] + 4'd3) : bcd[4*i +: 4];
    end
  end

  always_comb begin
    case (mode)
      MODE_HEX: emit_nib = src[31:28];
      MODE_BIN: emit_nib = {3'b000, src[31]};
      MODE_DEC: emit_nib = bcd[39:36];
      default:  emit_nib = 4'd0;
    endcase
  end

  assign emit_last = (rem == 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      o_valid <= 1'b0;
    end else begin
      if (char_load) begin
        o_valid <= 1'b1;
      end else if (item_out.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_in.valid && ld_ok) begin
            mode   <= ld_mode;
            neg    <= ld_neg;
            src    <= ld_src;
            rem    <= ld_rem;
            bitcnt <= ld_bits;
            bcd    <= 40'd0;
            cnt    <= 6'd0;
            state  <= (ld_mode == MODE_DEC) ? ST_CONV : ST_EMIT;
          end
        end
        ST_CONV: begin
          bcd    <= {bcd_adj[38:0], src[31]};
          src    <= {src[30:0], 1'b0};
          bitcnt <= bitcnt - 6'd1;
          if (bitcnt == 6'd1) begin
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (bcd[39:36] == 4'd0 && rem != 6'd1) begin
            bcd <= {bcd[35:0], 4'd0};
            rem <= rem - 6'd1;
          end else begin
            state <= neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            o_data.ascii_char <= iaf_pkg::CHAR_MINUS;
            o_data.last_char  <= 1'b0;
            o_data.char_count <= 6'd0;
            cnt               <= 6'd1;
            state             <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            o_data.ascii_char <= iaf_pkg::digit_char(emit_nib);
            o_data.last_char  <= emit_last;
            o_data.char_count <= emit_last ? (cnt + 6'd1) : 6'd0;
            cnt               <= cnt + 6'd1;
            rem               <= rem - 6'd1;
            src               <= (mode == MODE_BIN) ? {src[30:0], 1'b0} : {src[27:0], 4'd0};
            bcd               <= {bcd[35:0], 4'd0};
            if (emit_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_last_has_count: assert property (@(posedge clk) disable iff (rst)
    item_out.valid && item_out.data.last_char |-> item_out.data.char_count != 6'd0)
    else $error("final character without a count");

  a_load_starts_run: assert property (@(posedge clk) disable iff (rst)
    item_in.valid && item_in.ready && ld_ok |=> state != ST_IDLE)
    else $error("valid format did not start a run");

  a_emit_has_chars: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> rem != 6'd0)
    else $error("emit state with no characters left");

endmodule
